// File: rtl/sr_pkg.sv
// ----------------------------------------------------------------------------
// sr_pkg: shared constants and types for the systematic resampler
// Holds the particle limits, field widths and the control/status bundles
// exchanged between the resampler controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sr_pkg;

    // Particle storage limits
    localparam int MAX_PARTICLES = 64;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

    // Field widths
    localparam int WEIGHT_W = 32;
    localparam int FRAC_W   = 16;
    localparam int TOTAL_W  = WEIGHT_W + IDX_W;           // sum of all weights
    localparam int PROD_W   = FRAC_W + TOTAL_W;           // u * T
    localparam int THR_W    = FRAC_W + IDX_W + TOTAL_W;   // (m + u) * T
    localparam int WN_W     = WEIGHT_W + CNT_W;           // w * n
    localparam int CN_W     = TOTAL_W + IDX_W;            // c * n

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // accept one weight beat
        logic init;        // form u*T, read first weight, clear walk counters
        logic first;       // seed running c*n from the first weight
        logic accum;       // add the fetched weight into c*n, advance index
        logic emit;        // emit the current index for this slot
        logic emit_degen;  // emit the identity index, degenerate
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic advance;     // threshold above c*n and index below n-1
        logic last_slot;   // current slot is n-1
        logic total_zero;  // latched total weight is zero
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/systematic_resampler.sv
// ----------------------------------------------------------------------------
// systematic_resampler: low-variance systematic resampling of particle weights
//
// Input: a beat is taken when start is high and busy is low. Each beat
// carries one Q1.31 weight; the beat with i_final_weight high also carries
// the Q0.16 draw u and launches the run. Up to 64 weights are held; extra
// weights of a load are dropped.
// Non-final beats leave busy low, so loading runs at one weight a cycle.
// After the final beat busy stays high for the run: setup in INIT and FIRST,
// then a WALK step per emitted slot, each index advance going through WALK
// and FETCH for the weight memory read and prefix accumulate; an all-zero
// load goes from INIT to DEGEN. A result beat comes the cycle after its slot.
// Output: one result beat per slot on o_result_valid, registered, one cycle
// each; the receiver has no backpressure. o_run_end marks the last beat and
// o_degenerate marks an all-zero load (identity indices).
// Reset (synchronous, active low) empties the load and drops any run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module systematic_resampler (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [sr_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                        i_final_weight,
    input  wire logic [sr_pkg::FRAC_W-1:0]   i_draw_fraction,
    output logic                             o_result_valid,
    output logic [sr_pkg::IDX_W-1:0]         o_chosen_index,
    output logic                             o_degenerate,
    output logic                             o_run_end
);
    import sr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer
    sr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_final_weight (i_final_weight),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .busy           (busy)
    );

    // Weight store and walk arithmetic
    sr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_weight        (i_weight),
        .i_final_weight  (i_final_weight),
        .i_draw_fraction (i_draw_fraction),
        .o_stat          (w_stat),
        .o_result_valid  (o_result_valid),
        .o_chosen_index  (o_chosen_index),
        .o_degenerate    (o_degenerate),
        .o_run_end       (o_run_end)
    );

endmodule

`default_nettype wire

// File: rtl/sr_datapath.sv
// ----------------------------------------------------------------------------
// sr_datapath: weight store, totals and resampling walk registers
// Loads weights into a local memory, keeps the running total, then walks the
// prefix sums against the systematic threshold under controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sr_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sr_pkg::t_cmd                i_cmd,
    input  wire logic [sr_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                        i_final_weight,
    input  wire logic [sr_pkg::FRAC_W-1:0]   i_draw_fraction,
    output sr_pkg::t_stat                    o_stat,
    output logic                             o_result_valid,
    output logic [sr_pkg::IDX_W-1:0]         o_chosen_index,
    output logic                             o_degenerate,
    output logic                             o_run_end
);
    import sr_pkg::*;

    // Weight memory
    logic [WEIGHT_W-1:0] r_mem [MAX_PARTICLES];
    logic [WEIGHT_W-1:0] r_rdata;
    logic [IDX_W-1:0]    w_rd_addr;

    // Load state
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                w_room;

    // Run state
    logic [CNT_W-1:0]    r_n;
    logic [TOTAL_W-1:0]  r_tot;
    logic [FRAC_W-1:0]   r_u;
    logic [THR_W-1:0]    r_thr;
    logic [CN_W-1:0]     r_cn;
    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_m;

    logic [PROD_W-1:0]   w_ut;
    logic [WN_W-1:0]     w_wn;
    logic [CNT_W-1:0]    w_n_minus1;

    // Output beat registers
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic                r_out_degen;
    logic                r_out_end;

    assign w_room     = (r_count < CNT_W'(MAX_PARTICLES));
    assign w_rd_addr  = i_cmd.init ? '0 : (r_i + IDX_W'(1));
    assign w_ut       = r_u * r_tot;
    assign w_wn       = r_rdata * r_n;
    assign w_n_minus1 = r_n - CNT_W'(1);

    // Next load count and total including the incoming weight
    always_comb begin
        n_count = r_count;
        n_total = r_total;
        if (w_room) begin
            n_count = r_count + CNT_W'(1);
            n_total = r_total + TOTAL_W'(i_weight);
        end
    end

    // Write on load, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_mem[r_count[IDX_W-1:0]] <= i_weight;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // Hold load count and running total; clear at the final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmd.load) begin
            if (i_final_weight) begin
                r_count <= '0;
                r_total <= '0;
            end else begin
                r_count <= n_count;
                r_total <= n_total;
            end
        end
    end

    // Latch run parameters at the final beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_final_weight) begin
            r_n   <= n_count;
            r_tot <= n_total;
            r_u   <= i_draw_fraction;
        end
    end

    // Walk registers: threshold, prefix product, index and slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_thr <= THR_W'(w_ut);
            r_i   <= '0;
            r_m   <= '0;
        end
        if (i_cmd.first) begin
            r_cn <= CN_W'(w_wn);
        end
        if (i_cmd.accum) begin
            r_cn <= r_cn + CN_W'(w_wn);
            r_i  <= r_i + IDX_W'(1);
        end
        if (i_cmd.emit || i_cmd.emit_degen) begin
            r_m   <= r_m + IDX_W'(1);
            r_thr <= r_thr + {{IDX_W{1'b0}}, r_tot, {FRAC_W{1'b0}}};
        end
    end

    // Drive the result beat for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit || i_cmd.emit_degen;
        end
        r_out_idx   <= i_cmd.emit_degen ? r_m : r_i;
        r_out_degen <= i_cmd.emit_degen;
        r_out_end   <= o_stat.last_slot;
    end

    // Status back to the controller
    assign o_stat.advance    = (r_thr > {r_cn, {FRAC_W{1'b0}}})
                               && ({1'b0, r_i} < w_n_minus1);
    assign o_stat.last_slot  = ({1'b0, r_m} == w_n_minus1);
    assign o_stat.total_zero = (r_tot == '0);

    assign o_result_valid = r_out_valid;
    assign o_chosen_index = r_out_idx;
    assign o_degenerate   = r_out_degen;
    assign o_run_end      = r_out_end;

endmodule

`default_nettype wire

// File: rtl/sr_ctrl.sv
// ----------------------------------------------------------------------------
// sr_ctrl: resampler sequencer
// Accepts weight beats while idle, then steps the datapath through threshold
// setup, the prefix-sum walk unless the total is zero, and a result per slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_final_weight,
    input  wire sr_pkg::t_stat i_stat,
    output sr_pkg::t_cmd       o_cmd,
    output logic               busy
);
    import sr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_FIRST = 6'b000100,
        S_WALK  = 6'b001000,
        S_FETCH = 6'b010000,
        S_DEGEN = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start && i_final_weight) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_stat.total_zero ? S_DEGEN : S_FIRST;
            end
            S_FIRST: begin
                o_cmd.first = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (i_stat.advance) begin
                    n_state = S_FETCH;
                end else begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_slot) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.accum = 1'b1;
                n_state     = S_WALK;
            end
            S_DEGEN: begin
                o_cmd.emit_degen = 1'b1;
                if (i_stat.last_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire
